// ===== design/pucs_pkg.sv =====
// ----------------------------------------------------------------------------
// pucs_pkg: shared types and constants for the per-user CRC statistics core
// Record layout, statistic select codes and reset values of a cleared record.
// ----------------------------------------------------------------------------
package pucs_pkg;

	localparam int NumUsersDef = 32;
	localparam int HistBinsDef = 16;

	// statistic word select codes
	localparam logic [4:0] SEL_TX       = 5'd0;
	localparam logic [4:0] SEL_SUCCESS  = 5'd1;
	localparam logic [4:0] SEL_HARQ     = 5'd2;
	localparam logic [4:0] SEL_WORST    = 5'd3;
	localparam logic [4:0] SEL_SINR_MIN = 5'd4;
	localparam logic [4:0] SEL_SINR_MAX = 5'd5;
	localparam logic [4:0] SEL_SINR_SUM = 5'd6;
	localparam logic [4:0] SEL_SINR_CNT = 5'd7;
	localparam logic [4:0] SEL_RSRP_MIN = 5'd8;
	localparam logic [4:0] SEL_RSRP_MAX = 5'd9;
	localparam logic [4:0] SEL_RSRP_SUM = 5'd10;
	localparam logic [4:0] SEL_RSRP_CNT = 5'd11;
	localparam logic [4:0] SEL_USED     = 5'd12;
	localparam logic [4:0] SEL_HIST0    = 5'd13;

	localparam logic [0:0] ACT_UPDATE = 1'b0;
	localparam logic [0:0] ACT_READ   = 1'b1;

	typedef struct packed {
		logic [31:0]       tx_count;
		logic [31:0]       success_count;
		logic [31:0]       harq_fail_count;
		logic [15:0]       worst_failed_retx;
		logic signed [7:0] sinr_min;
		logic signed [7:0] sinr_max;
		logic [31:0]       sinr_sum;
		logic [31:0]       sinr_count;
		logic signed [8:0] rsrp_min;
		logic signed [8:0] rsrp_max;
		logic [31:0]       rsrp_sum;
		logic [31:0]       rsrp_count;
	} scalar_rec_t;

	// listed from the top bit down, so action lands in bit 0 of the beat
	typedef struct packed {
		logic [4:0]        read_select;
		logic signed [8:0] rsrp_db;
		logic              rsrp_valid;
		logic signed [7:0] sinr_db;
		logic              sinr_valid;
		logic              crc_ok;
		logic [15:0]       retx_limit;
		logic [15:0]       retx_cnt;
		logic              processed;
		logic [4:0]        ue_index;
		logic              action;
	} item_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC
	} state_t;

	function automatic scalar_rec_t cleared_rec();
		scalar_rec_t r;
		r = '0;
		r.sinr_min = 8'sd127;
		r.sinr_max = -8'sd128;
		r.rsrp_min = 9'sd255;
		r.rsrp_max = -9'sd256;
		return r;
	endfunction

endpackage

// ===== design/pucs_scalar_mem.sv =====
// ----------------------------------------------------------------------------
// pucs_scalar_mem: per-user scalar statistics record store
// One record per user slot, one write port, registered read port.
// ----------------------------------------------------------------------------
module pucs_scalar_mem #(
	parameter int NUM_USERS = pucs_pkg::NumUsersDef,
	parameter int AW        = 5
) (
	input  logic                  clk,
	input  logic [AW-1:0]         rd_addr,
	output pucs_pkg::scalar_rec_t rd_data,
	input  logic                  wr_en,
	input  logic [AW-1:0]         wr_addr,
	input  pucs_pkg::scalar_rec_t wr_data
);
	import pucs_pkg::*;

	scalar_rec_t mem [NUM_USERS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

// ===== design/pucs_hist_mem.sv =====
// ----------------------------------------------------------------------------
// pucs_hist_mem: per-user retransmission histogram store
// Addressed by {user, bin}; one write port, registered read port.
// ----------------------------------------------------------------------------
module pucs_hist_mem #(
	parameter int DEPTH = pucs_pkg::NumUsersDef * pucs_pkg::HistBinsDef,
	parameter int AW    = 9
) (
	input  logic          clk,
	input  logic [AW-1:0] rd_addr,
	output logic [31:0]   rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [31:0]   wr_data
);
	logic [31:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

// ===== design/per_ue_crc_stats_accumulator_core.sv =====
// ----------------------------------------------------------------------------
// per_ue_crc_stats_accumulator_core: per-user uplink CRC statistics
// Read-modify-write of a per-user record and histogram bin held in memories.
// ----------------------------------------------------------------------------
// Flow: an accepted beat and the memory reads are registered, then the EXEC
// state applies the update, writes the record back and registers the output
// beat; no new item is taken in EXEC, nor while the output beat stalls.
// Reset: slot-used flags and the recorded flag clear at once; a clearing pass
// then zeroes all NUM_USERS * 2^clog2(HIST_BINS) histogram entries (512 by default)
// with s_tready low; records clear on a slot's first update.
module per_ue_crc_stats_accumulator_core #(
	parameter int NUM_USERS = pucs_pkg::NumUsersDef,
	parameter int HIST_BINS = pucs_pkg::HistBinsDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// action, ue_index, processed, retx_cnt, retx_limit, crc_ok, sinr_valid,
	// sinr_db, rsrp_valid, rsrp_db, read_select (64 bits, no pad)
	input  logic [63:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// read_data[32:0], entry_used, any_recorded (40 bits, 5 pad)
	output logic [39:0] m_tdata
);
	import pucs_pkg::*;

	localparam int UW = (NUM_USERS > 1) ? $clog2(NUM_USERS) : 1;
	localparam int BW = $clog2(HIST_BINS);
	localparam int HW = UW + BW;
	localparam int HIST_DEPTH = NUM_USERS << BW;
	localparam logic [HW-1:0] CLR_LAST = HW'(HIST_DEPTH - 1);

	state_t state_q, state_d;
	item_t  it_s1;
	logic   load;
	logic   clr_active;
	logic [HW-1:0] clr_q;

	logic [NUM_USERS-1:0] used_q;
	logic                 recorded_q;
	logic                 out_valid_q;
	logic [39:0]          out_data_q;

	item_t in_it;
	assign in_it = item_t'(s_tdata);

	logic          in_range;
	logic [UW-1:0] ue;
	assign in_range = ({27'd0, it_s1.ue_index} < 32'(NUM_USERS));
	assign ue       = UW'(it_s1.ue_index);

	// histogram bin: update uses clamped retx, read uses select - 13
	logic [BW-1:0] bin_upd, bin_rd, bin_sel;
	logic          sel_is_hist;
	always_comb begin
		bin_upd = (in_it.retx_cnt < 16'(HIST_BINS - 1)) ? BW'(in_it.retx_cnt)
			: BW'(HIST_BINS - 1);
		bin_rd  = BW'(in_it.read_select - SEL_HIST0);
		bin_sel = (in_it.action == ACT_READ) ? bin_rd : bin_upd;
	end
	logic [BW-1:0] bin_s1;
	assign sel_is_hist = (it_s1.read_select >= SEL_HIST0) &&
		({27'd0, it_s1.read_select} < 32'(HIST_BINS) + 32'd13);

	scalar_rec_t rec_rd, rec_wr;
	logic [31:0] hist_rd, hist_wr;
	logic        wr_en;
	logic          hist_we;
	logic [HW-1:0] hist_waddr;
	logic [31:0]   hist_wdata;

	assign hist_we    = wr_en || clr_active;
	assign hist_waddr = clr_active ? clr_q : {ue, bin_s1};
	assign hist_wdata = clr_active ? 32'd0 : hist_wr;

	pucs_scalar_mem #(.NUM_USERS(NUM_USERS), .AW(UW)) u_scalar (
		.clk(clk), .rd_addr(UW'(in_it.ue_index)), .rd_data(rec_rd),
		.wr_en(wr_en), .wr_addr(ue), .wr_data(rec_wr)
	);
	pucs_hist_mem #(.DEPTH(HIST_DEPTH), .AW(HW)) u_hist (
		.clk(clk), .rd_addr({UW'(in_it.ue_index), bin_sel}), .rd_data(hist_rd),
		.wr_en(hist_we), .wr_addr(hist_waddr), .wr_data(hist_wdata)
	);

	always_comb begin
		state_d    = state_q;
		s_tready   = 1'b0;
		load       = 1'b0;
		clr_active = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				// zero one histogram entry per cycle
				clr_active = 1'b1;
				if (clr_q == CLR_LAST) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				s_tready = !out_valid_q || m_tready;
				load     = s_tvalid && s_tready;
				if (load) state_d = ST_EXEC;
			end
			ST_EXEC: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (clr_active) clr_q <= clr_q + HW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			it_s1  <= in_it;
			bin_s1 <= bin_sel;
		end
	end

	// modify stage
	logic        slot_used, upd;
	scalar_rec_t base;
	logic [31:0] hist_base;
	logic [32:0] rd_word;
	always_comb begin
		slot_used = in_range && used_q[ue];
		upd = (state_q == ST_EXEC) && (it_s1.action == ACT_UPDATE) &&
			it_s1.processed && in_range;
		wr_en = upd;
		base      = slot_used ? rec_rd : cleared_rec();
		hist_base = slot_used ? hist_rd : 32'd0;
		rec_wr  = base;
		hist_wr = hist_base + 32'd1;
		rec_wr.tx_count = base.tx_count + 32'd1;
		if (it_s1.crc_ok) begin
			rec_wr.success_count = base.success_count + 32'd1;
		end else begin
			if (base.worst_failed_retx < it_s1.retx_cnt)
				rec_wr.worst_failed_retx = it_s1.retx_cnt;
			if (it_s1.retx_cnt >= it_s1.retx_limit)
				rec_wr.harq_fail_count = base.harq_fail_count + 32'd1;
		end
		if (it_s1.sinr_valid) begin
			if (it_s1.sinr_db < base.sinr_min) rec_wr.sinr_min = it_s1.sinr_db;
			if (it_s1.sinr_db > base.sinr_max) rec_wr.sinr_max = it_s1.sinr_db;
			rec_wr.sinr_sum   = base.sinr_sum + 32'(it_s1.sinr_db);
			rec_wr.sinr_count = base.sinr_count + 32'd1;
		end
		if (it_s1.rsrp_valid) begin
			if (it_s1.rsrp_db < base.rsrp_min) rec_wr.rsrp_min = it_s1.rsrp_db;
			if (it_s1.rsrp_db > base.rsrp_max) rec_wr.rsrp_max = it_s1.rsrp_db;
			rec_wr.rsrp_sum   = base.rsrp_sum + 32'(it_s1.rsrp_db);
			rec_wr.rsrp_count = base.rsrp_count + 32'd1;
		end

		rd_word = '0;
		if (it_s1.action == ACT_READ && slot_used) begin
			unique case (it_s1.read_select)
				SEL_TX:       rd_word = {1'b0, rec_rd.tx_count};
				SEL_SUCCESS:  rd_word = {1'b0, rec_rd.success_count};
				SEL_HARQ:     rd_word = {1'b0, rec_rd.harq_fail_count};
				SEL_WORST:    rd_word = {17'd0, rec_rd.worst_failed_retx};
				SEL_SINR_MIN: rd_word = 33'(rec_rd.sinr_min);
				SEL_SINR_MAX: rd_word = 33'(rec_rd.sinr_max);
				SEL_SINR_SUM: rd_word = {rec_rd.sinr_sum[31], rec_rd.sinr_sum};
				SEL_SINR_CNT: rd_word = {1'b0, rec_rd.sinr_count};
				SEL_RSRP_MIN: rd_word = 33'(rec_rd.rsrp_min);
				SEL_RSRP_MAX: rd_word = 33'(rec_rd.rsrp_max);
				SEL_RSRP_SUM: rd_word = {rec_rd.rsrp_sum[31], rec_rd.rsrp_sum};
				SEL_RSRP_CNT: rd_word = {1'b0, rec_rd.rsrp_count};
				SEL_USED:     rd_word = 33'd1;
				default:      rd_word = sel_is_hist ? {1'b0, hist_rd} : 33'd0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q      <= '0;
			recorded_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (upd) begin
				used_q[ue] <= 1'b1;
				recorded_q <= 1'b1;
			end
			if (state_q == ST_EXEC) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EXEC) begin
			out_data_q <= {5'd0, recorded_q || upd, slot_used || upd, rd_word};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	a_used_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		recorded_q |=> recorded_q) else $error("recorded flag dropped");
	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EXEC) |-> !load) else $error("load during execute");
	a_out_after_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EXEC) |=> m_tvalid) else $error("result lost");
	a_upd_sets_rec: assert property (@(posedge clk) disable iff (!arst_n)
		upd |=> recorded_q) else $error("recorded flag not set");

endmodule
